[rtl/tlv_enc_pkg.sv]
// Shared types, constants and helper functions of the TLV scalar field encoder.
package tlv_enc_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 64;
    localparam int LEN_W   = 4;
    localparam int OP_W    = 2;

    localparam int SINGLE_W = 32;

    // Field kinds carried on the input sideband.
    typedef enum logic [OP_W-1:0] {
        OP_INT    = 2'd0,
        OP_SINGLE = 2'd1,
        OP_DOUBLE = 2'd2,
        OP_END    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_TAG,
        ST_LEN,
        ST_DATA,
        ST_END
    } state_t;

    // Single precision NaN: exponent all ones and a nonzero mantissa.
    function automatic logic single_is_nan(input logic [SINGLE_W-1:0] bits);
        single_is_nan = (bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0);
    endfunction

    // Double precision NaN: exponent all ones and a nonzero mantissa.
    function automatic logic double_is_nan(input logic [VALUE_W-1:0] bits);
        double_is_nan = (bits[62:52] == 11'h7FF) && (bits[51:0] != 52'd0);
    endfunction

endpackage

[rtl/tlv_scalar_field_encoder.sv]
// Top level of the TLV scalar field encoder: byte-serial tag, length and value output.
//
// Usage. One scalar field enters per transaction on the s_axis channel: tuser carries the
// kind (integer, single float bits, double float bits, end of list), tdata carries the tag
// byte and the 64-bit value. The encoded bytes leave one per transaction on m_axis, with
// tlast set on the final byte of the field. The end code byte for end-of-list items is
// written via cfg_we / cfg_wdata; the user must do so only while the block is idle (unenforced).
//
// Sequencing. After acceptance the value register is normalized one byte per cycle,
// dropping leading zero bytes, with a final check in ST_NORM. Then tag, length and the
// value bytes follow, one per cycle while the receiver does not stall, most significant
// first. The length byte counts the significant bytes: eight less the leading zero bytes.
// An end-of-list item sends only the end code byte, with tlast; a NaN float item sends
// nothing. Value bytes shift out of the value register through a single output
// register; one field is in work at a time.
//
// Reset clears the state machine, the output valid flag and the end code (to zero).
// When the receiver holds m_axis_tready low, the output register keeps its byte and the
// sequencer waits; no byte is lost or repeated.
module tlv_scalar_field_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata fields from bit 0 up: tag [7:0], value [71:8].
    input  logic [tlv_enc_pkg::BYTE_W+tlv_enc_pkg::VALUE_W-1:0] s_axis_tdata,
    // tuser fields from bit 0 up: op [1:0].
    input  logic [tlv_enc_pkg::OP_W-1:0]    s_axis_tuser,
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata fields from bit 0 up: out_byte [7:0].
    output logic [tlv_enc_pkg::BYTE_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,
    // Configuration: end code register.
    input  logic                            cfg_we,
    input  logic [tlv_enc_pkg::BYTE_W-1:0]  cfg_wdata
);
    import tlv_enc_pkg::*;

    localparam int TOP_LSB = VALUE_W - BYTE_W;

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     val_reg, val_next;
    logic [BYTE_W-1:0]      tag_reg, tag_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [BYTE_W-1:0]      end_code_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]      out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic                   in_fire;
    logic                   slot_free;
    logic                   top_zero;
    logic                   emit;
    logic [BYTE_W-1:0]      emit_byte;
    logic                   emit_last;
    op_t                    in_op;
    logic [BYTE_W-1:0]      in_tag;
    logic [VALUE_W-1:0]     in_value;
    logic [VALUE_W-1:0]     in_value_masked;
    logic                   in_nan;

    assign in_op    = op_t'(s_axis_tuser);
    assign in_tag   = s_axis_tdata[BYTE_W-1:0];
    assign in_value = s_axis_tdata[BYTE_W+VALUE_W-1:BYTE_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // The output register can take a new byte when empty or being drained.
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign top_zero  = (val_reg[VALUE_W-1:TOP_LSB] == '0);

    // Single floats only keep the low word; NaN patterns of either width emit nothing.
    always_comb
    begin
        in_value_masked = in_value;
        in_nan          = 1'b0;
        case (in_op)
            OP_SINGLE:
            begin
                in_value_masked = {{(VALUE_W-SINGLE_W){1'b0}}, in_value[SINGLE_W-1:0]};
                in_nan          = single_is_nan(in_value[SINGLE_W-1:0]);
            end
            OP_DOUBLE:
            begin
                in_nan = double_is_nan(in_value);
            end
            default:
            begin
                in_nan = 1'b0;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == OP_END)
                    begin
                        state_next = ST_END;
                    end
                    else if (!in_nan)
                    begin
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM:
            begin
                if (len_reg == '0 || !top_zero)
                begin
                    state_next = ST_TAG;
                end
            end
            ST_TAG:
            begin
                if (slot_free)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (slot_free)
                begin
                    state_next = (len_reg == '0) ? ST_IDLE : ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (slot_free && len_reg == LEN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_END:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output byte selection.
    always_comb
    begin
        val_next  = val_reg;
        tag_next  = tag_reg;
        len_next  = len_reg;
        emit      = 1'b0;
        emit_byte = '0;
        emit_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    val_next = in_value_masked;
                    tag_next = in_tag;
                    len_next = LEN_W'(VALUE_W / BYTE_W);
                end
            end
            ST_NORM:
            begin
                if (len_reg != '0 && top_zero)
                begin
                    val_next = {val_reg[TOP_LSB-1:0], {BYTE_W{1'b0}}};
                    len_next = len_reg - LEN_W'(1);
                end
            end
            ST_TAG:
            begin
                emit      = slot_free;
                emit_byte = tag_reg;
            end
            ST_LEN:
            begin
                emit      = slot_free;
                emit_byte = {{(BYTE_W-LEN_W){1'b0}}, len_reg};
                emit_last = (len_reg == '0);
            end
            ST_DATA:
            begin
                emit      = slot_free;
                emit_byte = val_reg[VALUE_W-1:TOP_LSB];
                emit_last = (len_reg == LEN_W'(1));
                if (slot_free)
                begin
                    val_next = {val_reg[TOP_LSB-1:0], {BYTE_W{1'b0}}};
                    len_next = len_reg - LEN_W'(1);
                end
            end
            ST_END:
            begin
                emit      = slot_free;
                emit_byte = end_code_reg;
                emit_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_byte;
            out_last_next  = emit_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            end_code_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                end_code_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        tag_reg      <= tag_next;
        len_reg      <= len_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // The byte count never exceeds the width of the value in bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_END) |-> (len_reg <= LEN_W'(VALUE_W / BYTE_W)))
        else $error("byte count out of range");

    // Value bytes are only sent while some remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (len_reg != '0))
        else $error("data state with no bytes left");

    // After normalization the top byte is significant unless the value was zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAG) |-> (len_reg == '0 || !top_zero))
        else $error("value not normalized before tag");

    // A byte is never loaded over one the receiver has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !emit)
        else $error("output byte overwritten while stalled");

endmodule
